[design/mfu_pkg.sv]
// Shared constants, codes and control structures of the multicycle functional unit.
package mfu_pkg;

  // Local data memory.
  localparam int MEM_WORDS = 1024;
  localparam int ADDR_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  // Iterative divider.
  localparam int DIV_STEPS = 32;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Command codes of an input item.
  localparam logic [1:0] CMD_ISSUE   = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_COLLECT = 2'd2;
  localparam logic [1:0] CMD_RELEASE = 2'd3;

  // Unit kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_MUL  = 2'd2;
  localparam logic [1:0] KIND_MEM  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_UNIT_KIND   = 2'd0;
  localparam logic [1:0] CFG_FIRST_CYC   = 2'd1;
  localparam logic [1:0] CFG_SECOND_CYC  = 2'd2;

  // Source of the output register.
  localparam logic [1:0] SEL_NOW  = 2'd0;
  localparam logic [1:0] SEL_DIV  = 2'd1;
  localparam logic [1:0] SEL_LOAD = 2'd2;

  localparam logic [7:0] CNT_MAX = 8'd255;

  typedef struct packed {
    logic              take;
    logic              out_load;
    logic [1:0]        out_sel;
    logic              div_start;
    logic              div_step;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic needs_load;
  } dp_stat_t;

endpackage

[design/mfu_if.sv]
// Handshake channel interfaces of the multicycle functional unit.
interface mfu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] first_operand;
  logic signed [31:0] second_operand;
  logic signed [31:0] third_operand;
  logic               op_select;

  modport source (output valid, cmd, first_operand, second_operand, third_operand,
                  op_select, input ready);
  modport sink   (input valid, cmd, first_operand, second_operand, third_operand,
                  op_select, output ready);
endinterface

interface mfu_out_if;
  logic               valid;
  logic               ready;
  logic               unit_busy;
  logic               unit_ready;
  logic               result_valid;
  logic signed [31:0] result_value;
  logic signed [31:0] result_tag;
  logic               result_error;

  modport source (output valid, unit_busy, unit_ready, result_valid, result_value,
                  result_tag, result_error, input ready);
  modport sink   (input valid, unit_busy, unit_ready, result_valid, result_value,
                  result_tag, result_error, output ready);
endinterface

interface mfu_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/mfu_div.sv]
// Iterative signed divider, one restoring shift-subtract step per cycle while step is high.
module mfu_div (
  input  logic        clk,
  input  logic        start,
  input  logic        step,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient
);
  import mfu_pkg::*;

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r;
  logic        neg_r;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend[31] ? (32'd0 - dividend) : dividend;
    end else if (step) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg_r <= dividend[31] ^ divisor[31];
    end
  end

  // The most negative dividend over minus one wraps back to itself here.
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;

endmodule

[design/mfu_datapath.sv]
// Datapath: configuration, held operands, counter, data memory, divider and output register.
module mfu_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mfu_pkg::ctrl_cmd_t  ctrl,
  output mfu_pkg::dp_stat_t   stat,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic [1:0]          in_cmd,
  input  logic [31:0]         in_first,
  input  logic [31:0]         in_second,
  input  logic [31:0]         in_third,
  input  logic                in_op,
  output logic                o_busy,
  output logic                o_ready,
  output logic                o_valid,
  output logic [31:0]         o_value,
  output logic [31:0]         o_tag,
  output logic                o_error
);
  import mfu_pkg::*;

  logic [1:0]  kind_r;
  logic [7:0]  first_cyc_r, second_cyc_r;
  logic        busy_r, busy_nxt;
  logic        rdy_r, rdy_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [31:0] held_a_r, held_b_r, held_c_r;
  logic        held_op_r;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rd_data_r;

  logic [32:0]       addr_sum;
  logic              addr_ok;
  logic [ADDR_W-1:0] addr_idx;
  logic [7:0]        lat;
  logic              is_collect;
  logic              store_we;
  logic [31:0]       product;
  logic [31:0]       div_q;

  logic        now_valid, now_error;
  logic [31:0] now_value, now_tag;

  // Address is the exact 33-bit sum of the two held operands.
  assign addr_sum   = {held_a_r[31], held_a_r} + {held_b_r[31], held_b_r};
  assign addr_ok    = !addr_sum[32] && (addr_sum < 33'(MEM_WORDS));
  assign addr_idx   = addr_sum[ADDR_W-1:0];
  assign is_collect = (in_cmd == CMD_COLLECT);
  assign product    = held_a_r * held_b_r;
  assign lat        = held_op_r ? first_cyc_r : second_cyc_r;

  assign stat.needs_div  = is_collect && (kind_r == KIND_MUL) && !held_op_r
                           && (held_b_r != '0);
  assign stat.needs_load = is_collect && (kind_r == KIND_MEM) && !held_op_r && addr_ok;
  assign store_we        = ctrl.take && is_collect && (kind_r == KIND_MEM) && held_op_r
                           && addr_ok;

  mfu_div u_div (
    .clk      (clk),
    .start    (ctrl.div_start),
    .step     (ctrl.div_step),
    .dividend (held_a_r),
    .divisor  (held_b_r),
    .quotient (div_q)
  );

  always_comb begin
    busy_nxt = busy_r;
    rdy_nxt  = rdy_r;
    cnt_nxt  = cnt_r;
    case (in_cmd)
      CMD_ISSUE: begin
        busy_nxt = 1'b1;
      end
      CMD_TICK: begin
        if (cnt_r >= lat) begin
          rdy_nxt = 1'b1;
        end else if (cnt_r != CNT_MAX) begin
          cnt_nxt = cnt_r + 8'd1;
        end
      end
      CMD_RELEASE: begin
        busy_nxt = 1'b0;
        rdy_nxt  = 1'b0;
        cnt_nxt  = 8'd1;
      end
      default: begin
      end
    endcase
  end

  // Results that are ready in the cycle the item is taken.
  always_comb begin
    now_valid = 1'b0;
    now_error = 1'b0;
    now_value = '0;
    now_tag   = '0;
    if (is_collect) begin
      case (kind_r)
        KIND_ADD: begin
          now_valid = 1'b1;
          now_value = held_op_r ? (held_a_r + held_b_r) : (held_a_r - held_b_r);
          now_tag   = held_c_r;
        end
        KIND_MUL: begin
          now_valid = 1'b1;
          if (held_op_r) begin
            now_value = product;
            now_tag   = held_c_r;
          end else begin
            now_error = (held_b_r == '0);
          end
        end
        KIND_MEM: begin
          now_valid = 1'b1;
          now_error = !addr_ok;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r       <= KIND_ADD;
      first_cyc_r  <= 8'd1;
      second_cyc_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UNIT_KIND:  kind_r       <= cfg_data[1:0];
        CFG_FIRST_CYC:  first_cyc_r  <= cfg_data;
        CFG_SECOND_CYC: second_cyc_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rdy_r     <= 1'b0;
      cnt_r     <= 8'd1;
      held_a_r  <= '0;
      held_b_r  <= '0;
      held_c_r  <= '0;
      held_op_r <= 1'b0;
    end else if (ctrl.take) begin
      busy_r <= busy_nxt;
      rdy_r  <= rdy_nxt;
      cnt_r  <= cnt_nxt;
      if (in_cmd == CMD_ISSUE) begin
        held_a_r  <= in_first;
        held_b_r  <= in_second;
        held_c_r  <= in_third;
        held_op_r <= in_op;
      end else if (in_cmd == CMD_RELEASE) begin
        held_a_r  <= '0;
        held_b_r  <= '0;
        held_c_r  <= '0;
        held_op_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr_we) begin
      mem[ctrl.clr_addr] <= '0;
    end else if (store_we) begin
      mem[addr_idx] <= held_c_r;
    end
    if (ctrl.take) begin
      rd_data_r <= mem[addr_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      case (ctrl.out_sel)
        SEL_DIV: begin
          o_busy  <= busy_r;
          o_ready <= rdy_r;
          o_valid <= 1'b1;
          o_value <= div_q;
          o_tag   <= held_c_r;
          o_error <= 1'b0;
        end
        SEL_LOAD: begin
          o_busy  <= busy_r;
          o_ready <= rdy_r;
          o_valid <= 1'b1;
          o_value <= rd_data_r;
          o_tag   <= held_c_r;
          o_error <= 1'b0;
        end
        default: begin
          o_busy  <= busy_nxt;
          o_ready <= rdy_nxt;
          o_valid <= now_valid;
          o_value <= now_value;
          o_tag   <= now_tag;
          o_error <= now_error;
        end
      endcase
    end
  end

endmodule

[design/mfu_ctrl.sv]
// Controller: memory clearing pass, command sequencing and output handshake.
module mfu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mfu_pkg::dp_stat_t  stat,
  output mfu_pkg::ctrl_cmd_t ctrl
);
  import mfu_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_DFIN  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    dcnt_nxt      = dcnt_r;
    in_ready      = 1'b0;
    ctrl          = '0;
    ctrl.clr_addr = clr_r;
    case (state_r)
      ST_CLEAR: begin
        ctrl.clr_we = 1'b1;
        clr_nxt     = clr_r + 1'b1;
        if (clr_r == ADDR_W'(MEM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready  = !out_valid_r || out_ready;
        ctrl.take = in_valid && in_ready;
        if (ctrl.take) begin
          if (stat.needs_div) begin
            ctrl.div_start = 1'b1;
            dcnt_nxt       = '0;
            state_nxt      = ST_DIV;
          end else if (stat.needs_load) begin
            state_nxt = ST_LOAD;
          end else begin
            ctrl.out_load = 1'b1;
            ctrl.out_sel  = SEL_NOW;
          end
        end
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        dcnt_nxt      = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DFIN;
        end
      end
      ST_DFIN: begin
        ctrl.out_load = 1'b1;
        ctrl.out_sel  = SEL_DIV;
        state_nxt     = ST_IDLE;
      end
      ST_LOAD: begin
        ctrl.out_load = 1'b1;
        ctrl.out_sel  = SEL_LOAD;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/multicycle_functional_unit.sv]
// Top level of the multicycle functional unit: controller and datapath joined.
//
//  Channel  Direction  Carries
//  in_ch    sink       cmd, first_operand, second_operand, third_operand, op_select
//  out_ch   source     unit_busy, unit_ready, result_valid, result_value,
//                      result_tag, result_error
//  cfg_ch   sink       index (unit_kind, first_op_cycles, second_op_cycles), data
//
//  Every item gives exactly one result item. Issue, tick, release and most collects
//  write their result to the output register as the item is taken.
//  A load collect waits on the registered read of the data memory and ends in ST_LOAD.
//  A divide collect loads the divider as it is taken, 32 shift-subtract steps follow
//  and ST_DFIN signs the quotient; the divider is the one long path of the unit.
//  After reset the data memory is cleared one word a cycle, all MEM_WORDS (1024) words,
//  with in_ch.ready low; configuration writes are taken throughout.
//  A new item is taken while the previous result is being taken from the output.
module multicycle_functional_unit (
  input logic      clk,
  input logic      rst_n,
  mfu_in_if.sink   in_ch,
  mfu_out_if.source out_ch,
  mfu_cfg_if.sink  cfg_ch
);
  import mfu_pkg::*;

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;
  logic [31:0] value_w;
  logic [31:0] tag_w;

  // Registers can always be written out of reset; the datapath latches them at once.
  assign cfg_ch.ready = 1'b1;

  mfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  mfu_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .in_cmd    (in_ch.cmd),
    .in_first  (in_ch.first_operand),
    .in_second (in_ch.second_operand),
    .in_third  (in_ch.third_operand),
    .in_op     (in_ch.op_select),
    .o_busy    (out_ch.unit_busy),
    .o_ready   (out_ch.unit_ready),
    .o_valid   (out_ch.result_valid),
    .o_value   (value_w),
    .o_tag     (tag_w),
    .o_error   (out_ch.result_error)
  );

  // The result fields are signed on the channel.
  assign out_ch.result_value = $signed(value_w);
  assign out_ch.result_tag   = $signed(tag_w);

endmodule

[tb/multicycle_functional_unit_tb.sv]
// Self-checking testbench of the multicycle functional unit, with directed and random tests.
`timescale 1ns / 1ps

module multicycle_functional_unit_tb;
  import mfu_pkg::*;

  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  // One result item as the unit should present it.
  typedef struct packed {
    logic        busy;
    logic        rdy;
    logic        vld;
    logic [31:0] value;
    logic [31:0] tag;
    logic        err;
  } fu_result_t;

  logic clk;
  logic rst_n;

  mfu_in_if  in_ch ();
  mfu_out_if out_ch ();
  mfu_cfg_if cfg_ch ();

  multicycle_functional_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Our own copy of the unit's registers and working state. It is advanced once for
  // every item the unit takes, so the awaited results follow the order of issue.
  logic [1:0]         kind_q;
  logic [7:0]         first_lat_q;
  logic [7:0]         second_lat_q;
  logic               busy_q;
  logic               rdy_q;
  logic               op_q;
  logic [7:0]         count_q;
  logic signed [31:0] a_q;
  logic signed [31:0] b_q;
  logic signed [31:0] c_q;
  logic [31:0]        mem_q [MEM_WORDS];

  fu_result_t awaited[$];

  int in_idle_pct;
  int out_idle_pct;
  int items_sent;
  int results_seen;
  int collects_done;
  int faults_flagged;
  int reg_writes;
  int errors;
  int phase_no;

  // The clock runs freely with a period of 10 ns.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, changing its mind only at the falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= out_idle_pct);
    end
  end

  // A hard limit on the run, well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results still awaited.", awaited.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Release and reset leave the working state in the same cleared condition.
  task automatic clear_unit_model();
    busy_q  = 1'b0;
    rdy_q   = 1'b0;
    count_q = 8'd1;
    a_q     = '0;
    b_q     = '0;
    c_q     = '0;
    op_q    = 1'b0;
  endtask

  // Works out the result item of one command and advances the state copy.
  task automatic execute_command(input logic [1:0] cmd, input logic signed [31:0] a,
                                 input logic signed [31:0] b, input logic signed [31:0] c,
                                 input logic op, output fu_result_t r);
    longint sa;
    longint sb;
    longint addr;
    logic [7:0] lat;
    r  = '0;
    sa = longint'(a_q);
    sb = longint'(b_q);
    case (cmd)
      CMD_ISSUE: begin
        // The counter and the ready flag survive an issue over a busy unit.
        a_q    = a;
        b_q    = b;
        c_q    = c;
        op_q   = op;
        busy_q = 1'b1;
      end
      CMD_TICK: begin
        lat = op_q ? first_lat_q : second_lat_q;
        if (count_q >= lat) begin
          rdy_q = 1'b1;
        end else if (count_q < CNT_MAX) begin
          count_q++;
        end
      end
      CMD_COLLECT: begin
        // A collect works on whatever is held, ready or not, and keeps the state.
        case (kind_q)
          KIND_ADD: begin
            r.vld   = 1'b1;
            r.value = op_q ? 32'(sa + sb) : 32'(sa - sb);
            r.tag   = c_q;
          end
          KIND_MUL: begin
            r.vld = 1'b1;
            if (op_q) begin
              r.value = 32'(sa * sb);
              r.tag   = c_q;
            end else if (sb == 0) begin
              r.err = 1'b1;
            end else begin
              // Division of 64-bit values truncates toward zero, and the most
              // negative word over minus one comes back as itself once cut to 32 bits.
              r.value = 32'(sa / sb);
              r.tag   = c_q;
            end
          end
          KIND_MEM: begin
            // The address is the exact sum, so two large negatives do not wrap to zero.
            addr  = sa + sb;
            r.vld = 1'b1;
            if (addr < 0 || addr >= MEM_WORDS) begin
              r.err = 1'b1;
            end else if (op_q) begin
              mem_q[addr[ADDR_W-1:0]] = c_q;
            end else begin
              r.value = mem_q[addr[ADDR_W-1:0]];
              r.tag   = c_q;
            end
          end
          default: begin
          end
        endcase
      end
      default: clear_unit_model();
    endcase
    r.busy = busy_q;
    r.rdy  = rdy_q;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t ns: result %0d, %s expected %h, got %h", $time, results_seen, name,
               exp_v, act_v);
    end
  endtask

  // Everything is sampled at the rising edge: results are checked against the oldest
  // awaited item, taken items are run through the state copy, and register writes
  // update its configuration.
  always @(posedge clk) begin : track
    fu_result_t oldest;
    fu_result_t fresh;
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (awaited.size() == 0) begin
          errors++;
          $display("%0t ns: result item arrived with nothing awaited", $time);
        end else begin
          oldest = awaited.pop_front();
          check_field("unit_busy", 32'(oldest.busy), 32'(out_ch.unit_busy));
          check_field("unit_ready", 32'(oldest.rdy), 32'(out_ch.unit_ready));
          check_field("result_valid", 32'(oldest.vld), 32'(out_ch.result_valid));
          check_field("result_value", oldest.value, out_ch.result_value);
          check_field("result_tag", oldest.tag, out_ch.result_tag);
          check_field("result_error", 32'(oldest.err), 32'(out_ch.result_error));
        end
        results_seen++;
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        execute_command(in_ch.cmd, in_ch.first_operand, in_ch.second_operand,
                        in_ch.third_operand, in_ch.op_select, fresh);
        awaited.push_back(fresh);
        if (fresh.vld) collects_done++;
        if (fresh.err) faults_flagged++;
      end
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        case (cfg_ch.index)
          CFG_UNIT_KIND:  kind_q       = cfg_ch.data[1:0];
          CFG_FIRST_CYC:  first_lat_q  = cfg_ch.data;
          CFG_SECOND_CYC: second_lat_q = cfg_ch.data;
          default: begin
          end
        endcase
        reg_writes++;
      end
    end
  end

  // Offers one item from the next falling edge, after a random gap, and returns at the
  // rising edge that takes it. The valid line stays high when items follow back to back.
  task automatic send_cmd(input logic [1:0] cmd, input logic signed [31:0] a,
                          input logic signed [31:0] b, input logic signed [31:0] c,
                          input logic op);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.cmd            = cmd;
    in_ch.first_operand  = a;
    in_ch.second_operand = b;
    in_ch.third_operand  = c;
    in_ch.op_select      = op;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic issue(input logic signed [31:0] a, input logic signed [31:0] b,
                       input logic signed [31:0] c, input logic op);
    send_cmd(CMD_ISSUE, a, b, c, op);
  endtask

  task automatic tick_unit();
    send_cmd(CMD_TICK, '0, '0, '0, 1'b0);
  endtask

  task automatic collect_result();
    send_cmd(CMD_COLLECT, '0, '0, '0, 1'b0);
  endtask

  task automatic free_unit();
    send_cmd(CMD_RELEASE, '0, '0, '0, 1'b0);
  endtask

  // Stops offering items and waits until every awaited result has been taken.
  // Each item yields exactly one result, so the unit is idle once the queue is empty.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    settle();
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_config(input logic [1:0] kind, input logic [7:0] first_lat,
                            input logic [7:0] second_lat);
    write_reg(CFG_UNIT_KIND, {6'd0, kind});
    write_reg(CFG_FIRST_CYC, first_lat);
    write_reg(CFG_SECOND_CYC, second_lat);
  endtask

  // Operands lean towards the word extremes, zero, plus and minus one and small values.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return 0;
      3: return -1;
      4: return 1;
      5, 6: return $urandom_range(200) - 100;
      default: return $urandom;
    endcase
  endfunction

  // Adder with its reset settings: a tick and a collect before anything was issued,
  // a wrapping sum collected with no tick of its own, and a wrapping difference issued
  // over a busy unit so that the ready flag must be kept.
  task automatic test_add_sub();
    tick_unit();
    collect_result();
    issue(WORD_MAX, WORD_MAX, WORD_MIN, 1'b1);
    collect_result();
    tick_unit();
    issue(WORD_MIN, 1, -1, 1'b0);
    collect_result();
    free_unit();
  endtask

  // Multiplier and divider: the most negative word over minus one, rounding toward
  // zero, division by zero and a product that overflows.
  task automatic test_mul_div();
    set_config(KIND_MUL, 8'd2, 8'd3);
    issue(WORD_MIN, -1, 5, 1'b0);
    collect_result();
    issue(-7, 2, 6, 1'b0);
    collect_result();
    issue(123, 0, 7, 1'b0);
    collect_result();
    issue(WORD_MAX, WORD_MIN, 8, 1'b1);
    collect_result();
  endtask

  // Load and store: a store to the top word, a load of it through an offset, an
  // address whose exact sum is far below zero though its low bits are zero, and a
  // store to a negative address.
  task automatic test_load_store();
    set_config(KIND_MEM, 8'd1, 8'd1);
    issue(MEM_WORDS - 1, 0, 32'sh5a5a_c3c3, 1'b1);
    collect_result();
    issue(512, MEM_WORDS - 513, 77, 1'b0);
    collect_result();
    issue(WORD_MIN, WORD_MIN, 1, 1'b0);
    collect_result();
    issue(-1, 0, 2, 1'b1);
    collect_result();
  endtask

  // With no kind selected a collect carries nothing.
  task automatic test_no_result();
    set_config(KIND_NONE, 8'd1, 8'd1);
    issue(1, 2, 3, 1'b1);
    collect_result();
  endtask

  // The longest latency needs the counter to climb all the way to its top; a latency
  // of zero must be met by the very first tick.
  task automatic test_counter_limit();
    set_config(KIND_ADD, 8'd0, CNT_MAX);
    free_unit();
    issue(100, 23, -5, 1'b0);
    repeat (256) tick_unit();
    issue(7, 8, 9, 1'b1);
    tick_unit();
    collect_result();
    free_unit();
    issue(-3, 4, 11, 1'b1);
    tick_unit();
    collect_result();
    free_unit();
  endtask

  // Random items in two settings per call. Most are issue, tick and collect sequences
  // with random content, mostly closed by a release; the rest are loose commands of any kind.
  task automatic test_random(input int in_pct, input int out_pct, input int n_items);
    int stop_at;
    int sub;
    int a;
    int b;
    int addr;
    int lim;
    logic op;
    settle();
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (sub = 0; sub < 2; sub++) begin
      case (phase_no % 6)
        0: set_config(KIND_ADD, 8'd1, 8'd1);
        1: set_config(KIND_MUL, 8'($urandom_range(6)), 8'($urandom_range(6)));
        2: set_config(KIND_MEM, 8'($urandom_range(6)), 8'($urandom_range(6)));
        3: set_config(KIND_NONE, CNT_MAX, 8'd0);
        4: set_config(KIND_MUL, 8'd0, 8'($urandom_range(1, 4)));
        default: set_config(KIND_MEM, 8'($urandom_range(1, 4)), 8'd0);
      endcase
      phase_no++;
      stop_at = items_sent + n_items / 2;
      while (items_sent < stop_at) begin
        if ($urandom_range(99) < 80) begin
          op = 1'($urandom_range(1));
          if (kind_q == KIND_MEM && $urandom_range(9) < 8) begin
            // Keep most addresses in a small window so loads meet earlier stores,
            // with the edges of the memory and just beyond them now and then.
            case ($urandom_range(9))
              0: addr = MEM_WORDS - 1;
              1: addr = MEM_WORDS;
              2: addr = -1;
              default: addr = $urandom_range(15);
            endcase
            b = $urandom_range(2000) - 1000;
            a = addr - b;
          end else begin
            a = pick_word();
            b = pick_word();
          end
          issue(a, b, $urandom, op);
          if ($urandom_range(7) == 0) issue(pick_word(), pick_word(), $urandom, ~op);
          lim = int'(op ? first_lat_q : second_lat_q);
          if (lim > 6) lim = 6;
          repeat ($urandom_range(lim + 1)) tick_unit();
          collect_result();
          if ($urandom_range(3) != 0) free_unit();
        end else begin
          send_cmd(2'($urandom_range(3)), pick_word(), pick_word(), pick_word(),
                   1'($urandom_range(1)));
        end
        // Now and then the sender holds back until the unit has nothing left to give.
        if ($urandom_range(39) == 0) settle();
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_ISSUE;
    in_ch.first_operand  = '0;
    in_ch.second_operand = '0;
    in_ch.third_operand  = '0;
    in_ch.op_select      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_UNIT_KIND;
    cfg_ch.data          = '0;
    in_idle_pct          = 23;
    out_idle_pct         = 73;
    items_sent           = 0;
    results_seen         = 0;
    collects_done        = 0;
    faults_flagged       = 0;
    reg_writes           = 0;
    errors               = 0;
    phase_no             = 0;

    // The state copy starts from the reset condition, with the memory all zero as
    // the unit leaves it after its clearing pass.
    kind_q       = KIND_ADD;
    first_lat_q  = 8'd1;
    second_lat_q = 8'd1;
    clear_unit_model();
    for (int i = 0; i < MEM_WORDS; i++) mem_q[ADDR_W'(i)] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The directed tests run with the sender idling less often than the receiver.
    test_add_sub();
    test_mul_div();
    test_load_store();
    test_no_result();
    test_counter_limit();
    test_random(23, 73, 120);
    test_random(73, 23, 120);
    test_random(0, 0, 120);

    // Let the last results drain and keep the clock running before the summary.
    settle();
    repeat (40) @(posedge clk);

    $display("Sent %0d items and checked %0d results, %0d of them collected values.",
             items_sent, results_seen, collects_done);
    $display("Faults flagged by the unit: %0d; register writes: %0d; mismatches: %0d.",
             faults_flagged, reg_writes, errors);
    if (errors == 0 && awaited.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
design/mfu_pkg.sv
design/mfu_if.sv
design/mfu_div.sv
design/mfu_datapath.sv
design/mfu_ctrl.sv
design/multicycle_functional_unit.sv
tb/multicycle_functional_unit_tb.sv
